/* rtl/ead_pkg.sv */
// ead_pkg: shared types, layer tables, constants and helper functions for the
// exponential air density pipeline. Depends on nothing; used by ead_exp_term
// and exponential_air_density.
package ead_pkg;

    // altitude format and layer table
    localparam int ALT_INT_BITS = 12;
    localparam int TABLE_LEN    = 28;
    localparam int NUM_LAYERS   = 28;
    localparam int LAYER_W      = 5;
    localparam int BAND_W       = 11;

    // fixed point formats
    localparam int FRAC_W    = 32;          // log2 domain fraction bits
    localparam int SER_FRAC  = 60;          // series fraction bits
    localparam int SER_W     = 60;          // width of a series term and of y
    localparam int SUM_W     = SER_W + 2;   // series sum, value in [1,2]
    localparam int C_W       = 44;          // per-layer log2e/H slope
    localparam int C_SH      = 12;          // slope carries 12 fraction bits beyond Q32
    localparam int K_W       = 42;          // per-layer log2 offset, signed Q32
    localparam int Q_W       = 42;          // negated exponent, signed Q32
    localparam int T_W       = 40;          // slope times distance, Q32
    localparam int EXP_W     = 10;          // working exponent
    localparam int EXP_TERMS = 17;          // series terms that can be nonzero

    // result fields
    localparam int OUT_EXP_W   = 7;
    localparam int OUT_EXP_MAX = 127;
    localparam int STATUS_W    = 2;
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

    // ln2 in Q60
    localparam logic [63:0] LN2_Q60 = 64'h0B17_217F_7D1C_F79B;
    // log2(10) in Q32
    localparam longint LOG2_10_Q32 = 64'sd14267572527;
    // log2(e) in Q44 times 1000, scale heights are in metres
    localparam logic [63:0] L2E_K = 64'h1715_4765_2B83 * 64'd1000;

    typedef logic [BAND_W-1:0]        t_band_tab [TABLE_LEN];
    typedef int unsigned              t_int_tab  [TABLE_LEN];
    typedef logic [C_W-1:0]           t_c_tab    [TABLE_LEN];
    typedef logic signed [K_W-1:0]    t_k_tab    [TABLE_LEN];
    typedef logic [63:0]              t_pp       [4];

    // data that rides along with an item through the series stages
    typedef struct packed {
        logic               zero;
        logic [LAYER_W-1:0] layer;
        logic [EXP_W-1:0]   expo;
    } t_side;

    // lower km bound of each layer band
    localparam t_band_tab BAND_LOW = '{
        11'd0,   11'd25,  11'd30,  11'd40,  11'd50,  11'd60,  11'd70,
        11'd80,  11'd90,  11'd100, 11'd110, 11'd120, 11'd130, 11'd140,
        11'd150, 11'd180, 11'd200, 11'd250, 11'd300, 11'd350, 11'd400,
        11'd450, 11'd500, 11'd600, 11'd700, 11'd800, 11'd900, 11'd1000};

    // base density as four decimal digits times 10^-pow
    localparam t_int_tab RHO_DIGITS = '{
        1225, 3899, 1774, 3972, 1057, 3206, 8770, 1905, 3396, 5297, 9661, 2438,
        8484, 3845, 2070, 5464, 2789, 7248, 2418, 9518, 3725, 1585, 6967, 1454,
        3614, 1170, 5245, 3019};
    localparam t_int_tab RHO_POW10 = '{
        3, 5, 5, 6, 6, 7, 8, 8, 9, 10, 11, 11, 12, 12,
        12, 13, 13, 14, 14, 15, 15, 15, 16, 16, 17, 17, 18, 18};

    // log2(e)/H rounded, Q44 per km
    localparam t_c_tab C_TAB = '{
        C_W'((L2E_K + 64'd7249   / 64'd2) / 64'd7249),
        C_W'((L2E_K + 64'd6349   / 64'd2) / 64'd6349),
        C_W'((L2E_K + 64'd6682   / 64'd2) / 64'd6682),
        C_W'((L2E_K + 64'd7554   / 64'd2) / 64'd7554),
        C_W'((L2E_K + 64'd8382   / 64'd2) / 64'd8382),
        C_W'((L2E_K + 64'd7714   / 64'd2) / 64'd7714),
        C_W'((L2E_K + 64'd6549   / 64'd2) / 64'd6549),
        C_W'((L2E_K + 64'd5799   / 64'd2) / 64'd5799),
        C_W'((L2E_K + 64'd5382   / 64'd2) / 64'd5382),
        C_W'((L2E_K + 64'd5877   / 64'd2) / 64'd5877),
        C_W'((L2E_K + 64'd7263   / 64'd2) / 64'd7263),
        C_W'((L2E_K + 64'd9473   / 64'd2) / 64'd9473),
        C_W'((L2E_K + 64'd12636  / 64'd2) / 64'd12636),
        C_W'((L2E_K + 64'd16149  / 64'd2) / 64'd16149),
        C_W'((L2E_K + 64'd22523  / 64'd2) / 64'd22523),
        C_W'((L2E_K + 64'd29740  / 64'd2) / 64'd29740),
        C_W'((L2E_K + 64'd37105  / 64'd2) / 64'd37105),
        C_W'((L2E_K + 64'd45546  / 64'd2) / 64'd45546),
        C_W'((L2E_K + 64'd53628  / 64'd2) / 64'd53628),
        C_W'((L2E_K + 64'd53298  / 64'd2) / 64'd53298),
        C_W'((L2E_K + 64'd58515  / 64'd2) / 64'd58515),
        C_W'((L2E_K + 64'd60828  / 64'd2) / 64'd60828),
        C_W'((L2E_K + 64'd63822  / 64'd2) / 64'd63822),
        C_W'((L2E_K + 64'd71835  / 64'd2) / 64'd71835),
        C_W'((L2E_K + 64'd88667  / 64'd2) / 64'd88667),
        C_W'((L2E_K + 64'd124640 / 64'd2) / 64'd124640),
        C_W'((L2E_K + 64'd181050 / 64'd2) / 64'd181050),
        C_W'((L2E_K + 64'd268000 / 64'd2) / 64'd268000)};

    // log2 of a positive integer below 2^31 by repeated squaring, Q32
    function automatic logic [63:0] log2_q32(input int unsigned v);
        logic [63:0]  z;
        logic [63:0]  frac;
        int unsigned  n;
        n    = 0;
        frac = '0;
        for (int b = 0; b < 31; b++) begin
            if ((v >> (b + 1)) != 0) begin
                n = b + 1;
            end
        end
        z = 64'(v) << (31 - n);
        for (int s = 0; s < 32; s++) begin
            z    = (z * z) >> 31;
            frac = frac << 1;
            if (z >= 64'h1_0000_0000) begin
                z       = z >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(n) << 32) | frac;
    endfunction

    // per-layer offset pow10*log2(10) - log2(digits), built at elaboration
    function automatic t_k_tab build_k_tab();
        t_k_tab tab;
        longint gain;
        longint kv;
        for (int i = 0; i < TABLE_LEN; i++) begin
            gain   = longint'(log2_q32(RHO_DIGITS[i]));
            kv     = longint'(RHO_POW10[i]) * LOG2_10_Q32 - gain;
            tab[i] = K_W'(kv);
        end
        return tab;
    endfunction

    localparam t_k_tab K_TAB = build_k_tab();

    // four 32x32 partial products of a 64x64 multiply
    function automatic t_pp pp4(input logic [63:0] a, input logic [63:0] b);
        t_pp p;
        p[0] = {32'b0, a[31:0]}  * {32'b0, b[31:0]};
        p[1] = {32'b0, a[31:0]}  * {32'b0, b[63:32]};
        p[2] = {32'b0, a[63:32]} * {32'b0, b[31:0]};
        p[3] = {32'b0, a[63:32]} * {32'b0, b[63:32]};
        return p;
    endfunction

    // full 128-bit product from its partial products
    function automatic logic [127:0] sum_pp(input t_pp p);
        return {64'b0, p[0]} + {32'b0, p[1], 32'b0} + {32'b0, p[2], 32'b0}
             + {p[3], 64'b0};
    endfunction

endpackage

/* rtl/exponential_air_density.sv */
// exponential_air_density: layered exponential atmosphere, altitude in, density
// out as normalized mantissa and power of two. Depends on ead_pkg, ead_exp_term.
//
//   channel  signals                                           direction
//   in       i_in_valid / o_in_ready, i_altitude_km_q          beat in
//   out      o_out_valid / i_out_ready, o_density_mantissa,    beat out
//            o_density_exponent, o_layer_index, o_status
//
// One beat is taken every cycle while o_in_ready is high; each result passes
// eight front stages, the 2^f series of 16 terms of five stages each and one
// rounding stage. Reset clears only valid bits. An output register and a
// one-entry skid stage sit at the end; when the skid holds a result the whole
// pipeline freezes and o_in_ready drops.
module exponential_air_density #(
    parameter int ALT_FRAC_BITS = 16,
    parameter int MANT_BITS     = 24
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_in_valid,
    output logic                                                 o_in_ready,
    input  logic [ead_pkg::ALT_INT_BITS+ALT_FRAC_BITS-1:0]       i_altitude_km_q,
    output logic                                                 o_out_valid,
    input  logic                                                 i_out_ready,
    output logic [MANT_BITS-1:0]                                 o_density_mantissa,
    output logic [ead_pkg::OUT_EXP_W-1:0]                        o_density_exponent,
    output logic [ead_pkg::LAYER_W-1:0]                          o_layer_index,
    output logic [ead_pkg::STATUS_W-1:0]                         o_status
);
    import ead_pkg::*;

    localparam int HW           = ALT_INT_BITS + ALT_FRAC_BITS;
    localparam int TSH          = ALT_FRAC_BITS + C_SH;
    localparam int RND_SH       = SER_FRAC - MANT_BITS;
    localparam int MSH          = RND_SH + 1;
    localparam int MW1          = MANT_BITS + 1;
    localparam int FRONT_STAGES = 8;

    typedef struct packed {
        logic [MANT_BITS-1:0] mant;
        logic [OUT_EXP_W-1:0] expo;
        logic [LAYER_W-1:0]   layer;
        logic [STATUS_W-1:0]  status;
    } t_res;

    logic                      w_en;
    logic [FRONT_STAGES-1:0]   r_fvld;

    logic [ALT_INT_BITS-1:0]   w_alt;
    logic [LAYER_W-1:0]        n1_layer;
    logic [HW-1:0]             r1_h;
    logic                      r1_zero;
    logic [LAYER_W-1:0]        r1_layer;
    logic [HW-1:0]             r2_d;
    logic [C_W-1:0]            r2_c;
    logic signed [K_W-1:0]     r2_k, r3_k, r4_k;
    logic                      r2_zero, r3_zero, r4_zero, r5_zero;
    logic [LAYER_W-1:0]        r2_layer, r3_layer, r4_layer, r5_layer;
    t_pp                       r3_pp;
    logic [127:0]              w_prod_t;
    logic [T_W-1:0]            r4_t;
    logic signed [Q_W-1:0]     r5_q;
    logic signed [Q_W-1:0]     w_negq;
    logic [EXP_W-1:0]          n6_expo;
    logic [FRAC_W-1:0]         n6_f;
    logic [FRAC_W-1:0]         r6_f;
    t_side                     r6_side, r7_side, r8_side;
    t_pp                       r7_pp;
    logic [127:0]              w_prod_y;
    logic [SER_W-1:0]          r8_y;

    logic                      w_vld  [EXP_TERMS];
    logic [SER_W-1:0]          w_term [EXP_TERMS];
    logic [SER_W-1:0]          w_y    [EXP_TERMS];
    logic [SUM_W-1:0]          w_sum  [EXP_TERMS];
    t_side                     w_side [EXP_TERMS];

    logic                      r_b1_vld;
    logic [MW1-1:0]            r_b1_mant;
    t_side                     r_b1_side;
    t_res                      n_res;
    logic [MW1-1:0]            n_m;
    logic [EXP_W-1:0]          n_e;

    logic                      r_out_vld;
    logic                      r_skid_vld;
    t_res                      r_out;
    t_res                      r_skid;

    // whole pipeline advances unless the skid stage is occupied
    assign w_en       = !r_skid_vld;
    assign o_in_ready = w_en;

    // front valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= '0;
        end else if (w_en) begin
            r_fvld <= {r_fvld[FRONT_STAGES-2:0], i_in_valid};
        end
    end

    // layer search: last band whose lower bound the integer km reaches
    assign w_alt = i_altitude_km_q[HW-1 -: ALT_INT_BITS];
    always_comb begin
        n1_layer = '0;
        for (int i = 1; i < NUM_LAYERS; i++) begin
            if (w_alt >= ALT_INT_BITS'(BAND_LOW[i])) begin
                n1_layer = LAYER_W'(i);
            end
        end
    end

    // full products of the front multiplies
    assign w_prod_t = sum_pp(r3_pp);
    assign w_prod_y = sum_pp(r7_pp);
    assign w_negq   = -r5_q;

    // split -x into an integer exponent and a fraction for 2^f
    always_comb begin
        n6_expo = '0;
        n6_f    = '0;
        if (r5_q[Q_W-1] || r5_q == '0) begin
            n6_f = w_negq[FRAC_W-1:0];
        end else begin
            n6_expo = EXP_W'(r5_q[Q_W-2:FRAC_W]);
            if (r5_q[FRAC_W-1:0] != '0) begin
                n6_expo = n6_expo + EXP_W'(1);
                n6_f    = -r5_q[FRAC_W-1:0];
            end
        end
    end

    // front datapath stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1: capture and layer
            r1_h     <= i_altitude_km_q;
            r1_zero  <= (i_altitude_km_q == '0);
            r1_layer <= n1_layer;
            // stage 2: distance into the layer and its constants
            r2_d     <= r1_h - (HW'(BAND_LOW[r1_layer]) << ALT_FRAC_BITS);
            r2_c     <= C_TAB[r1_layer];
            r2_k     <= K_TAB[r1_layer];
            r2_zero  <= r1_zero;
            r2_layer <= r1_layer;
            // stage 3: partial products of distance times slope
            r3_pp    <= pp4(64'(r2_d), 64'(r2_c));
            r3_k     <= r2_k;
            r3_zero  <= r2_zero;
            r3_layer <= r2_layer;
            // stage 4: slope term in Q32
            r4_t     <= w_prod_t[TSH +: T_W];
            r4_k     <= r3_k;
            r4_zero  <= r3_zero;
            r4_layer <= r3_layer;
            // stage 5: negated log2 of the density
            r5_q     <= r4_k + $signed({{(Q_W-T_W){1'b0}}, r4_t});
            r5_zero  <= r4_zero;
            r5_layer <= r4_layer;
            // stage 6: exponent and fraction
            r6_f       <= n6_f;
            r6_side    <= '{zero: r5_zero, layer: r5_layer, expo: n6_expo};
            // stage 7: partial products of f times ln2
            r7_pp    <= pp4(64'(r6_f), LN2_Q60);
            r7_side  <= r6_side;
            // stage 8: y = f*ln2 in Q60, first series term
            r8_y     <= w_prod_y[FRAC_W +: SER_W];
            r8_side  <= r7_side;
        end
    end

    // series seed: sum = 1 + y, term = y
    assign w_vld[0]  = r_fvld[FRONT_STAGES-1];
    assign w_term[0] = r8_y;
    assign w_y[0]    = r8_y;
    assign w_sum[0]  = {2'b01, r8_y};
    assign w_side[0] = r8_side;

    // remaining series terms, one unit per divisor k
    for (genvar j = 1; j < EXP_TERMS; j++) begin : g_term
        ead_exp_term #(
            .KVAL (j + 1)
        ) u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[j-1]),
            .i_term  (w_term[j-1]),
            .i_y     (w_y[j-1]),
            .i_sum   (w_sum[j-1]),
            .i_side  (w_side[j-1]),
            .o_vld   (w_vld[j]),
            .o_term  (w_term[j]),
            .o_y     (w_y[j]),
            .o_sum   (w_sum[j]),
            .o_side  (w_side[j])
        );
    end

    // rounding stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
        end else if (w_en) begin
            r_b1_vld <= w_vld[EXP_TERMS-1];
        end
    end

    // round the sum to the mantissa width
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_mant <= MW1'((w_sum[EXP_TERMS-1] + (SUM_W'(1) << RND_SH)) >> MSH);
            r_b1_side <= w_side[EXP_TERMS-1];
        end
    end

    // rounding carry, underflow and zero altitude
    always_comb begin
        n_m = r_b1_mant;
        n_e = r_b1_side.expo;
        if (n_m[MANT_BITS]) begin
            n_m = n_m >> 1;
            if (n_e == '0) begin
                n_m = {1'b0, {MANT_BITS{1'b1}}};
            end else begin
                n_e = n_e - EXP_W'(1);
            end
        end
        n_res        = '0;
        n_res.layer  = r_b1_side.layer;
        priority if (r_b1_side.zero) begin
            n_res.layer  = '0;
            n_res.status = ST_ZERO;
        end else if (n_e > EXP_W'(OUT_EXP_MAX)) begin
            n_res.status = ST_UNDER;
        end else begin
            n_res.mant   = n_m[MANT_BITS-1:0];
            n_res.expo   = n_e[OUT_EXP_W-1:0];
            n_res.status = ST_OK;
        end
    end

    // output register and skid valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_out_ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_b1_vld) begin
            if (r_out_vld && !i_out_ready) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // output register and skid payload
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (r_b1_vld) begin
            if (r_out_vld && !i_out_ready) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_density_mantissa = r_out.mant;
    assign o_density_exponent = r_out.expo;
    assign o_layer_index      = r_out.layer;
    assign o_status           = r_out.status;

endmodule

/* rtl/ead_exp_term.sv */
// ead_exp_term: one term of the 2^f power series, term_k = floor(term*y/2^60/k),
// in five register stages, and its addition into the running sum.
// Depends on ead_pkg.
module ead_exp_term #(
    parameter int KVAL = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [ead_pkg::SER_W-1:0] i_term,
    input  logic [ead_pkg::SER_W-1:0] i_y,
    input  logic [ead_pkg::SUM_W-1:0] i_sum,
    input  ead_pkg::t_side            i_side,
    output logic                      o_vld,
    output logic [ead_pkg::SER_W-1:0] o_term,
    output logic [ead_pkg::SER_W-1:0] o_y,
    output logic [ead_pkg::SUM_W-1:0] o_sum,
    output ead_pkg::t_side            o_side
);
    import ead_pkg::*;

    // floor((2^64-1)/k): quotient estimate is low by at most one
    localparam logic [63:0] RECIP = 64'hFFFF_FFFF_FFFF_FFFF / 64'(KVAL);
    // remainder after the estimate is below 2k
    localparam int RW = $clog2(2 * KVAL) + 1;
    localparam logic [RW-1:0] KR = RW'(KVAL);

    logic [5:1]       r_v;
    t_pp              r1_pp;
    logic [SER_W-1:0] r1_y, r2_y, r3_y, r4_y, r5_y;
    logic [SUM_W-1:0] r1_sum, r2_sum, r3_sum, r4_sum, r5_sum;
    t_side            r1_side, r2_side, r3_side, r4_side, r5_side;
    logic [SER_W-1:0] r2_p;
    t_pp              r3_pp;
    logic [RW-1:0]    r3_plo;
    logic [SER_W-1:0] r4_q;
    logic             r4_inc;
    logic [SER_W-1:0] r5_term;

    logic [127:0]     w_prod1;
    logic [127:0]     w_prod2;
    logic [SER_W-1:0] w_qest;
    logic [RW-1:0]    w_rem;

    // product sums and remainder check
    assign w_prod1 = sum_pp(r1_pp);
    assign w_prod2 = sum_pp(r3_pp);
    assign w_qest  = w_prod2[64 +: SER_W];
    assign w_rem   = r3_plo - w_qest[RW-1:0] * KR;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:1], i_vld};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: partial products of term times y
            r1_pp   <= pp4(64'(i_term), 64'(i_y));
            r1_y    <= i_y;
            r1_sum  <= i_sum;
            r1_side <= i_side;
            // stage 2: product shifted down to Q60
            r2_p    <= w_prod1[SER_FRAC +: SER_W];
            r2_y    <= r1_y;
            r2_sum  <= r1_sum;
            r2_side <= r1_side;
            // stage 3: partial products against the reciprocal of k
            r3_pp   <= pp4(64'(r2_p), RECIP);
            r3_plo  <= r2_p[RW-1:0];
            r3_y    <= r2_y;
            r3_sum  <= r2_sum;
            r3_side <= r2_side;
            // stage 4: quotient estimate and its correction
            r4_q    <= w_qest;
            r4_inc  <= (w_rem >= KR);
            r4_y    <= r3_y;
            r4_sum  <= r3_sum;
            r4_side <= r3_side;
            // stage 5: exact term and running sum
            r5_term <= r4_q + SER_W'(r4_inc);
            r5_sum  <= r4_sum + SUM_W'(r4_q) + SUM_W'(r4_inc);
            r5_y    <= r4_y;
            r5_side <= r4_side;
        end
    end

    assign o_vld  = r_v[5];
    assign o_term = r5_term;
    assign o_y    = r5_y;
    assign o_sum  = r5_sum;
    assign o_side = r5_side;

endmodule
